// ----- hw/rtl/gte_pkg.sv -----
package gte_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;
	localparam int WORK_DEPTH   = 512;

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int PW  = EW + 1;
	localparam int WAW = $clog2(WORK_DEPTH);
	localparam int WCW = WAW + 1;
	localparam int WDW = (PW > VW) ? PW : VW;

	localparam int VFW  = 6;
	localparam int VCW  = 7;
	localparam int ORW  = 2;
	localparam int STW  = 2;
	localparam int IDXW = 1;
	localparam int CDW  = 7;

	localparam logic [PW-1:0] NO_EDGE = PW'(MAX_EDGES);

	localparam logic [STW-1:0] ST_OK    = 2'd0;
	localparam logic [STW-1:0] ST_FULL  = 2'd1;
	localparam logic [STW-1:0] ST_RANGE = 2'd2;
	localparam logic [STW-1:0] ST_OVF   = 2'd3;

	localparam logic [ORW-1:0] ORD_BFS = 2'd0;
	localparam logic [ORW-1:0] ORD_REC = 2'd1;
	localparam logic [ORW-1:0] ORD_STK = 2'd2;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TRAV = 1'b1;

	localparam logic [IDXW-1:0] REG_VERTEX_COUNT    = 1'd0;
	localparam logic [IDXW-1:0] REG_TRAVERSAL_ORDER = 1'd1;

	typedef struct packed {
		logic           action;
		logic [VFW-1:0] from_vertex;
		logic [VFW-1:0] to_vertex;
	} item_t;

	typedef struct packed {
		logic [VFW-1:0] visited_vertex;
		logic [STW-1:0] status;
		logic           last;
	} result_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_REPORT,
		OP_ADD_BEGIN,
		OP_ADD_LINK,
		OP_BFS_INIT,
		OP_STK_INIT,
		OP_REC_INIT,
		OP_BFS_POP,
		OP_STK_POP,
		OP_BFS_VISIT,
		OP_STK_VISIT,
		OP_WALK_HEAD,
		OP_WALK_EDGE,
		OP_REC_PUSH,
		OP_REC_TOP,
		OP_REC_EDGE,
		OP_REC_DST,
		OP_OVF,
		OP_FLUSH
	} dp_op_t;

	typedef struct packed {
		logic report;
		logic is_add;
		logic ord_rec;
		logic ord_stk;
		logic drained;
		logic e_none;
		logic d_new;
		logic full;
	} dp_stat_t;

endpackage

// ----- hw/rtl/gte_ctrl.sv -----
module gte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  gte_pkg::dp_stat_t stat,
	output gte_pkg::dp_op_t   op,
	output logic              busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_LINK,
		S_POP,
		S_VISIT,
		S_WALK_H,
		S_WALK_E,
		S_R_INIT,
		S_R_TOP,
		S_R_E,
		S_R_D,
		S_R_PUSH,
		S_OVF,
		S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		op      = gte_pkg::OP_IDLE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (stat.report) begin
						op = gte_pkg::OP_REPORT;
					end else if (stat.is_add) begin
						op      = gte_pkg::OP_ADD_BEGIN;
						state_d = S_ADD_LINK;
					end else if (stat.ord_rec) begin
						op      = gte_pkg::OP_REC_INIT;
						state_d = S_R_INIT;
					end else if (stat.ord_stk) begin
						op      = gte_pkg::OP_STK_INIT;
						state_d = S_POP;
					end else begin
						op      = gte_pkg::OP_BFS_INIT;
						state_d = S_POP;
					end
				end
			end
			S_ADD_LINK: begin
				op      = gte_pkg::OP_ADD_LINK;
				state_d = S_IDLE;
			end
			S_POP: begin
				if (stat.drained) begin
					op      = gte_pkg::OP_FLUSH;
					state_d = S_IDLE;
				end else begin
					op      = stat.ord_stk ? gte_pkg::OP_STK_POP : gte_pkg::OP_BFS_POP;
					state_d = S_VISIT;
				end
			end
			S_VISIT: begin
				op      = stat.ord_stk ? gte_pkg::OP_STK_VISIT : gte_pkg::OP_BFS_VISIT;
				state_d = S_WALK_H;
			end
			S_WALK_H: begin
				op      = gte_pkg::OP_WALK_HEAD;
				state_d = stat.e_none ? S_POP : S_WALK_E;
			end
			S_WALK_E: begin
				op = gte_pkg::OP_WALK_EDGE;
				if (stat.d_new && stat.full) begin
					state_d = S_OVF;
				end else if (stat.e_none) begin
					state_d = S_POP;
				end
			end
			S_R_INIT: begin
				op      = gte_pkg::OP_REC_PUSH;
				state_d = S_R_TOP;
			end
			S_R_TOP: begin
				if (stat.drained) begin
					op      = gte_pkg::OP_FLUSH;
					state_d = S_IDLE;
				end else begin
					op      = gte_pkg::OP_REC_TOP;
					state_d = S_R_E;
				end
			end
			S_R_E: begin
				op      = gte_pkg::OP_REC_EDGE;
				state_d = stat.e_none ? S_R_TOP : S_R_D;
			end
			S_R_D: begin
				op = gte_pkg::OP_REC_DST;
				if (stat.d_new) begin
					state_d = stat.full ? S_OVF : S_R_PUSH;
				end else begin
					state_d = S_R_TOP;
				end
			end
			S_R_PUSH: begin
				op      = gte_pkg::OP_REC_PUSH;
				state_d = S_R_TOP;
			end
			S_OVF: begin
				op      = gte_pkg::OP_OVF;
				state_d = S_FIN;
			end
			S_FIN: begin
				op      = gte_pkg::OP_FLUSH;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// ----- hw/rtl/gte_dpath.sv -----
module gte_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gte_pkg::item_t            item,
	input  logic                      cfg_we,
	input  logic [gte_pkg::IDXW-1:0]  cfg_index,
	input  logic [gte_pkg::CDW-1:0]   cfg_wdata,
	input  gte_pkg::dp_op_t           op,
	output gte_pkg::dp_stat_t         stat,
	output gte_pkg::result_t          result,
	output logic                      result_valid
);

	logic [gte_pkg::VW-1:0]  dst_mem  [gte_pkg::MAX_EDGES];
	logic [gte_pkg::PW-1:0]  nxt_mem  [gte_pkg::MAX_EDGES];
	logic [gte_pkg::EW-1:0]  head_mem [gte_pkg::MAX_VERTICES];
	logic [gte_pkg::EW-1:0]  tail_mem [gte_pkg::MAX_VERTICES];
	logic [gte_pkg::WDW-1:0] work_mem [gte_pkg::WORK_DEPTH];

	logic [gte_pkg::VCW-1:0]          vcount_q;
	logic [gte_pkg::ORW-1:0]          order_q;
	logic [gte_pkg::VW-1:0]           from_q;
	logic [gte_pkg::PW-1:0]           eu_q;
	logic [gte_pkg::WCW-1:0]          rd_q, ptr_q;
	logic [gte_pkg::MAX_VERTICES-1:0] mark_q, head_vld_q;
	gte_pkg::result_t                 pend_q, out_q;
	logic                             pend_v_q, out_v_q;

	logic [gte_pkg::VW-1:0]  dst_rd_q;
	logic [gte_pkg::PW-1:0]  nxt_rd_q;
	logic [gte_pkg::EW-1:0]  head_rd_q, tail_rd_q;
	logic                    head_hit_q;
	logic [gte_pkg::WDW-1:0] work_rd_q;

	logic                    dst_we, nxt_we, head_we, tail_we, work_we;
	logic [gte_pkg::EW-1:0]  dst_wa, nxt_wa, e_ra;
	logic [gte_pkg::VW-1:0]  dst_wd, head_wa, tail_wa, head_ra, tail_ra;
	logic [gte_pkg::PW-1:0]  nxt_wd;
	logic [gte_pkg::EW-1:0]  head_wd, tail_wd;
	logic [gte_pkg::WAW-1:0] work_wa, work_ra;
	logic [gte_pkg::WDW-1:0] work_wd;

	logic [gte_pkg::VW-1:0]           from_v, to_v, work_x;
	logic                             from_bad, to_bad, bfs, d_new, full, e_none;
	logic [gte_pkg::STW-1:0]          add_st;
	logic [gte_pkg::PW-1:0]           head_e, e_sel;
	logic [gte_pkg::WCW-1:0]          ptr_m1;
	logic [gte_pkg::EW-1:0]           eu_idx;
	logic                             emit_en, flush_en, report_en;
	gte_pkg::result_t                 emit_res, report_res;
	logic [gte_pkg::MAX_VERTICES-1:0] mark_d;

	assign from_v   = item.from_vertex[gte_pkg::VW-1:0];
	assign to_v     = item.to_vertex[gte_pkg::VW-1:0];
	assign from_bad = ({1'b0, item.from_vertex} >= vcount_q) ||
		({1'b0, item.from_vertex} >= gte_pkg::VCW'(gte_pkg::MAX_VERTICES));
	assign to_bad   = ({1'b0, item.to_vertex} >= vcount_q) ||
		({1'b0, item.to_vertex} >= gte_pkg::VCW'(gte_pkg::MAX_VERTICES));
	assign add_st   = (from_bad || to_bad) ? gte_pkg::ST_RANGE :
		((eu_q == gte_pkg::PW'(gte_pkg::MAX_EDGES)) ? gte_pkg::ST_FULL : gte_pkg::ST_OK);
	assign eu_idx   = eu_q[gte_pkg::EW-1:0];
	assign head_e   = head_hit_q ? {1'b0, head_rd_q} : gte_pkg::NO_EDGE;
	assign work_x   = work_rd_q[gte_pkg::VW-1:0];
	assign ptr_m1   = ptr_q - 1'b1;
	assign d_new    = !mark_q[dst_rd_q];
	assign full     = (ptr_q == gte_pkg::WCW'(gte_pkg::WORK_DEPTH));
	assign bfs      = (order_q != gte_pkg::ORD_REC) && (order_q != gte_pkg::ORD_STK);

	always_comb begin
		case (op)
			gte_pkg::OP_WALK_HEAD: e_sel = head_e;
			gte_pkg::OP_REC_EDGE:  e_sel = work_rd_q[gte_pkg::PW-1:0];
			default:               e_sel = nxt_rd_q;
		endcase
	end
	assign e_none = (e_sel >= gte_pkg::NO_EDGE);
	assign e_ra   = e_sel[gte_pkg::EW-1:0];

	assign stat.report  = (item.action == gte_pkg::ACT_ADD) ? (add_st != gte_pkg::ST_OK) :
		from_bad;
	assign stat.is_add  = (item.action == gte_pkg::ACT_ADD);
	assign stat.ord_rec = (order_q == gte_pkg::ORD_REC);
	assign stat.ord_stk = (order_q == gte_pkg::ORD_STK);
	assign stat.drained = bfs ? (rd_q == ptr_q) : (ptr_q == '0);
	assign stat.e_none  = e_none;
	assign stat.d_new   = d_new;
	assign stat.full    = full;

	assign report_res.visited_vertex = '0;
	assign report_res.status = (item.action == gte_pkg::ACT_ADD) ? add_st : gte_pkg::ST_RANGE;
	assign report_res.last   = 1'b1;

	always_comb begin
		dst_we  = 1'b0;
		dst_wa  = '0;
		dst_wd  = '0;
		nxt_we  = 1'b0;
		nxt_wa  = '0;
		nxt_wd  = '0;
		head_we = 1'b0;
		head_wa = '0;
		head_wd = '0;
		tail_we = 1'b0;
		tail_wa = '0;
		tail_wd = '0;
		work_we = 1'b0;
		work_wa = '0;
		work_wd = '0;
		work_ra = '0;
		head_ra = '0;
		tail_ra = '0;
		case (op)
			gte_pkg::OP_ADD_BEGIN: begin
				dst_we  = 1'b1;
				dst_wa  = eu_idx;
				dst_wd  = to_v;
				nxt_we  = 1'b1;
				nxt_wa  = eu_idx;
				nxt_wd  = gte_pkg::NO_EDGE;
				tail_ra = from_v;
			end
			gte_pkg::OP_ADD_LINK: begin
				if (head_vld_q[from_q]) begin
					nxt_we = 1'b1;
					nxt_wa = tail_rd_q;
					nxt_wd = eu_q;
				end else begin
					head_we = 1'b1;
					head_wa = from_q;
					head_wd = eu_idx;
				end
				tail_we = 1'b1;
				tail_wa = from_q;
				tail_wd = eu_idx;
			end
			gte_pkg::OP_BFS_INIT, gte_pkg::OP_STK_INIT: begin
				work_we = 1'b1;
				work_wd = gte_pkg::WDW'(from_v);
			end
			gte_pkg::OP_REC_INIT: head_ra = from_v;
			gte_pkg::OP_BFS_POP:  work_ra = rd_q[gte_pkg::WAW-1:0];
			gte_pkg::OP_STK_POP:  work_ra = ptr_m1[gte_pkg::WAW-1:0];
			gte_pkg::OP_BFS_VISIT, gte_pkg::OP_STK_VISIT: head_ra = work_x;
			gte_pkg::OP_WALK_EDGE: begin
				if (d_new && !full) begin
					work_we = 1'b1;
					work_wa = ptr_q[gte_pkg::WAW-1:0];
					work_wd = gte_pkg::WDW'(dst_rd_q);
				end
			end
			gte_pkg::OP_REC_PUSH: begin
				work_we = 1'b1;
				work_wa = ptr_q[gte_pkg::WAW-1:0];
				work_wd = gte_pkg::WDW'(head_e);
			end
			gte_pkg::OP_REC_TOP: work_ra = ptr_m1[gte_pkg::WAW-1:0];
			gte_pkg::OP_REC_DST: begin
				work_we = 1'b1;
				work_wa = ptr_m1[gte_pkg::WAW-1:0];
				work_wd = gte_pkg::WDW'(nxt_rd_q);
				head_ra = dst_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dst_we) begin
			dst_mem[dst_wa] <= dst_wd;
		end
		if (nxt_we) begin
			nxt_mem[nxt_wa] <= nxt_wd;
		end
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		if (tail_we) begin
			tail_mem[tail_wa] <= tail_wd;
		end
		if (work_we) begin
			work_mem[work_wa] <= work_wd;
		end
		dst_rd_q  <= dst_mem[e_ra];
		nxt_rd_q  <= nxt_mem[e_ra];
		head_rd_q <= head_mem[head_ra];
		tail_rd_q <= tail_mem[tail_ra];
		work_rd_q <= work_mem[work_ra];
	end

	always_comb begin
		mark_d    = mark_q;
		emit_en   = 1'b0;
		emit_res  = '0;
		flush_en  = 1'b0;
		report_en = 1'b0;
		case (op)
			gte_pkg::OP_REPORT: report_en = 1'b1;
			gte_pkg::OP_BFS_INIT: begin
				mark_d         = '0;
				mark_d[from_v] = 1'b1;
			end
			gte_pkg::OP_STK_INIT: mark_d = '0;
			gte_pkg::OP_REC_INIT: begin
				mark_d                  = '0;
				mark_d[from_v]          = 1'b1;
				emit_en                 = 1'b1;
				emit_res.visited_vertex = gte_pkg::VFW'(from_v);
			end
			gte_pkg::OP_BFS_VISIT: begin
				emit_en                 = 1'b1;
				emit_res.visited_vertex = gte_pkg::VFW'(work_x);
			end
			gte_pkg::OP_STK_VISIT: begin
				if (!mark_q[work_x]) begin
					mark_d[work_x]          = 1'b1;
					emit_en                 = 1'b1;
					emit_res.visited_vertex = gte_pkg::VFW'(work_x);
				end
			end
			gte_pkg::OP_WALK_EDGE: begin
				if (d_new && bfs) begin
					mark_d[dst_rd_q] = 1'b1;
				end
			end
			gte_pkg::OP_REC_DST: begin
				if (d_new) begin
					mark_d[dst_rd_q]        = 1'b1;
					emit_en                 = 1'b1;
					emit_res.visited_vertex = gte_pkg::VFW'(dst_rd_q);
				end
			end
			gte_pkg::OP_OVF: begin
				emit_en         = 1'b1;
				emit_res.status = gte_pkg::ST_OVF;
			end
			gte_pkg::OP_FLUSH: flush_en = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= gte_pkg::VCW'(gte_pkg::MAX_VERTICES);
			order_q    <= gte_pkg::ORD_BFS;
			from_q     <= '0;
			eu_q       <= '0;
			rd_q       <= '0;
			ptr_q      <= '0;
			mark_q     <= '0;
			head_vld_q <= '0;
			head_hit_q <= 1'b0;
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			out_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gte_pkg::REG_VERTEX_COUNT:    vcount_q <= cfg_wdata[gte_pkg::VCW-1:0];
					gte_pkg::REG_TRAVERSAL_ORDER: order_q  <= cfg_wdata[gte_pkg::ORW-1:0];
					default: begin
					end
				endcase
			end
			head_hit_q <= head_vld_q[head_ra];
			mark_q     <= mark_d;
			out_v_q    <= (op == gte_pkg::OP_ADD_LINK) || report_en ||
				((flush_en || emit_en) && pend_v_q);

			case (op)
				gte_pkg::OP_ADD_BEGIN: from_q <= from_v;
				gte_pkg::OP_ADD_LINK: begin
					head_vld_q[from_q] <= 1'b1;
					eu_q               <= eu_q + 1'b1;
					out_q              <= '{visited_vertex: '0, status: gte_pkg::ST_OK,
						last: 1'b1};
				end
				gte_pkg::OP_BFS_INIT, gte_pkg::OP_STK_INIT: begin
					rd_q  <= '0;
					ptr_q <= gte_pkg::WCW'(1);
				end
				gte_pkg::OP_REC_INIT: ptr_q <= '0;
				gte_pkg::OP_BFS_POP:  rd_q  <= rd_q + 1'b1;
				gte_pkg::OP_STK_POP:  ptr_q <= ptr_m1;
				gte_pkg::OP_WALK_EDGE: begin
					if (d_new && !full) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				gte_pkg::OP_REC_PUSH: ptr_q <= ptr_q + 1'b1;
				gte_pkg::OP_REC_EDGE: begin
					if (e_none) begin
						ptr_q <= ptr_m1;
					end
				end
				default: begin
				end
			endcase

			if (report_en) begin
				out_q <= report_res;
			end else if (flush_en) begin
				if (pend_v_q) begin
					out_q <= '{visited_vertex: pend_q.visited_vertex, status: pend_q.status,
						last: 1'b1};
				end
				pend_v_q <= 1'b0;
			end else if (emit_en) begin
				if (pend_v_q) begin
					out_q <= pend_q;
				end
				pend_q   <= emit_res;
				pend_v_q <= 1'b1;
			end
		end
	end

	assign result       = out_q;
	assign result_valid = out_v_q;

endmodule

// ----- hw/rtl/graph_traversal_engine_core.sv -----
// Graph store with breadth-first and depth-first traversal. A request is taken when start is
// high and busy is low. Every result appears on result for exactly one cycle with result_valid
// high; the receiver cannot stall, so it must capture each one as it comes. An add request gives
// one status result: a range or full error is registered straight from the request, and a good add
// gives its result after the link step. A traversal in breadth-first, stack or recursive mode is
// walked by the controller over the edge and work memories, one read per cycle each. Each vertex
// result leaves one step behind the walk, since last is known only when the walk ends.
module graph_traversal_engine_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  gte_pkg::item_t            item,
	output logic                      busy,
	input  logic                      cfg_we,
	input  logic [gte_pkg::IDXW-1:0]  cfg_index,
	input  logic [gte_pkg::CDW-1:0]   cfg_wdata,
	output gte_pkg::result_t          result,
	output logic                      result_valid
);

	gte_pkg::dp_op_t   op;
	gte_pkg::dp_stat_t stat;

	gte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	gte_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.op           (op),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
